### src/tmg_pkg.sv
// tmg_pkg: shared types, constants and elaboration-time helpers for the
// transform matrix generator (cordic gain, stage angles, latencies).
// no dependencies
package tmg_pkg;

  localparam int CordicStagesDef = 16;
  localparam int FracBitsDef     = 16;

  localparam int EntryW = 32;
  localparam int OpW    = 3;

  typedef enum logic [OpW-1:0] {
    OP_TRANSLATE = 3'd0,
    OP_SCALE     = 3'd1,
    OP_ROT_XYZ   = 3'd2,
    OP_ROT_X     = 3'd3,
    OP_ROT_Y     = 3'd4,
    OP_ROT_Z     = 3'd5
  } op_e;

  typedef logic signed [EntryW-1:0] entry_t;
  typedef entry_t mat_t [4][4];

  typedef struct packed {
    entry_t sin_v;
    entry_t cos_v;
  } sc_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    entry_t         vx;
    entry_t         vy;
    entry_t         vz;
  } ctx_t;

  // angles are counted in units of 1e-12 degree; 1e12 = 244140625 * 2^12
  localparam longint DegUnit    = 64'd1000000000000;
  localparam int     DegScale   = 244140625;
  localparam int     DegShift   = 12;
  localparam longint RadInUnits = 64'd57295779513082;
  localparam int     AtanLen    = 16;
  localparam int     AngW       = 50;
  localparam int     MergeLatency = 4;

  localparam longint AtanTab [AtanLen] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
    64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427
  };

  function automatic longint stage_angle(int i);
    if (i < AtanLen) return AtanTab[i];
    if (i >= 62) return 64'd0;
    return (RadInUnits + (longint'(1) << (i - 1))) >> i;
  endfunction

  // restoring long division, used only while elaborating
  function automatic longint unsigned udiv_u64(longint unsigned num,
                                               longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem  = rem - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // inverse cordic gain in Q2.30, isqrt of the Q60 product
  function automatic longint cordic_gain(int stages);
    longint unsigned p;
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    longint unsigned dv;
    p = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 62) begin
        dv = (64'd1 << (2 * i)) + 64'd1;
        p  = p - udiv_u64(p, dv);
      end
    end
    n = p;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // restoring steps that bring any 32-bit offset angle below 360 degrees
  function automatic int red_steps(int frac);
    longint full;
    int     n;
    full = longint'(360) << frac;
    n = 0;
    while ((full << n) < (longint'(1) << 32)) n++;
    return (n < 1) ? 1 : n;
  endfunction

  function automatic int lane_latency(int stages, int frac);
    return red_steps(frac) + stages + 6;
  endfunction

  // round half up by frac bits, saturate to 32-bit signed
  function automatic entry_t round_sat(logic signed [63:0] v, int frac);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (frac - 1))) >>> frac;
    if (t > 64'sd2147483647) return entry_t'(32'h7fff_ffff);
    if (t < -64'sd2147483648) return entry_t'(32'h8000_0000);
    return t[EntryW-1:0];
  endfunction

endpackage

### src/tmg_if.sv
// tmg_in_if / tmg_out_if: valid-ready channels of the transform matrix generator
// depends on tmg_pkg
interface tmg_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmg_pkg::OpW-1:0]       op_kind;
  logic signed [31:0]            x_value;
  logic signed [31:0]            y_value;
  logic signed [31:0]            z_value;

  modport source (output valid, op_kind, x_value, y_value, z_value, input ready);
  modport sink   (input valid, op_kind, x_value, y_value, z_value, output ready);
endinterface

interface tmg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] first_entry;
  logic signed [31:0] second_entry;
  logic signed [31:0] third_entry;
  logic signed [31:0] fourth_entry;
  logic               last_row;

  modport source (output valid, row_index, first_entry, second_entry, third_entry,
                  fourth_entry, last_row, input ready);
  modport sink   (input valid, row_index, first_entry, second_entry, third_entry,
                  fourth_entry, last_row, output ready);
endinterface

### src/tmg_sincos.sv
// tmg_sincos: one lane, angle in degrees to sine and cosine
// range reduction pipeline followed by a pipelined cordic; depends on tmg_pkg
module tmg_sincos #(
  parameter int CORDIC_STAGES = tmg_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = tmg_pkg::FracBitsDef
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  tmg_pkg::entry_t angle_i,
  output tmg_pkg::sc_t    sc_o
);

  localparam int     UW    = 34;
  localparam int     AW    = tmg_pkg::AngW;
  localparam int     XW    = 34;
  localparam int     IpW   = 9;
  localparam int     IpmW  = IpW + 28;
  localparam int     FpmW  = FRAC_BITS + 28;
  localparam int     RndW  = FRAC_BITS + 41;
  localparam longint Full  = longint'(360) << FRAC_BITS;
  localparam int     RedN  = tmg_pkg::red_steps(FRAC_BITS);
  localparam longint Off   = (longint'(1) << 31) % Full;
  localparam logic [UW-1:0] FullU = UW'(Full);
  localparam logic [UW-1:0] OffU  = UW'(Off);
  localparam logic signed [AW-1:0] Deg90  = AW'(90 * tmg_pkg::DegUnit);
  localparam logic signed [AW-1:0] Deg180 = AW'(180 * tmg_pkg::DegUnit);
  localparam logic signed [AW-1:0] Deg360 = AW'(360 * tmg_pkg::DegUnit);
  localparam logic signed [XW-1:0] Gain   = XW'(tmg_pkg::cordic_gain(CORDIC_STAGES));
  localparam logic signed [XW-1:0] Half   = XW'(1) <<< (29 - FRAC_BITS);

  // reduction modulo 360 degrees of angle + 2^31
  logic [UW-1:0] red_q [RedN];

  for (genvar j = 0; j < RedN; j++) begin : g_red
    localparam logic [UW-1:0] Sub = UW'(Full << (RedN - 1 - j));
    logic [UW-1:0] prev;
    if (j == 0) begin : g_first
      assign prev = {2'b00, angle_i ^ 32'h8000_0000};
    end else begin : g_next
      assign prev = red_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) red_q[j] <= (prev >= Sub) ? prev - Sub : prev;
    end
  end

  logic [UW-1:0]          r_q;
  logic [IpmW-1:0]        ipm_q;
  logic [FpmW-1:0]        fpm_q;
  logic [IpW-1:0]         ip;
  logic [FRAC_BITS-1:0]   fp;
  logic [RndW-1:0]        frac_rnd;
  logic signed [AW-1:0]   units_d, units_q;
  logic signed [AW-1:0]   wrap_q;
  logic signed [AW-1:0]   fold_d, fold_q;
  logic                   flip_d, flip_q;

  assign ip = IpW'(r_q >> FRAC_BITS);
  assign fp = r_q[FRAC_BITS-1:0];
  assign frac_rnd = (RndW'(fpm_q) << tmg_pkg::DegShift) + (RndW'(1) << (FRAC_BITS - 1));
  assign units_d = AW'((AW'(ipm_q) << tmg_pkg::DegShift) + AW'(frac_rnd >> FRAC_BITS));

  always_comb begin
    fold_d = wrap_q;
    flip_d = 1'b0;
    if (wrap_q > Deg90) begin
      fold_d = Deg180 - wrap_q;
      flip_d = 1'b1;
    end else if (wrap_q < -Deg90) begin
      fold_d = -Deg180 - wrap_q;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q     <= (red_q[RedN-1] >= OffU) ? red_q[RedN-1] - OffU
                                         : red_q[RedN-1] + FullU - OffU;
      ipm_q   <= IpmW'(ip) * IpmW'(tmg_pkg::DegScale);
      fpm_q   <= FpmW'(fp) * FpmW'(tmg_pkg::DegScale);
      units_q <= units_d;
      wrap_q  <= (units_q > Deg180) ? units_q - Deg360 : units_q;
      fold_q  <= fold_d;
      flip_q  <= flip_d;
    end
  end

  // cordic, one micro-rotation per stage
  logic signed [XW-1:0] x_q [CORDIC_STAGES];
  logic signed [XW-1:0] y_q [CORDIC_STAGES];
  logic signed [AW-1:0] a_q [CORDIC_STAGES];
  logic                 f_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [AW-1:0] Ang = AW'(tmg_pkg::stage_angle(i));
    logic signed [XW-1:0] xin, yin;
    logic signed [AW-1:0] ain;
    logic                 fin;
    if (i == 0) begin : g_first
      assign xin = Gain;
      assign yin = '0;
      assign ain = fold_q;
      assign fin = flip_q;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign ain = a_q[i-1];
      assign fin = f_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ain >= 0) begin
          x_q[i] <= xin - (yin >>> i);
          y_q[i] <= yin + (xin >>> i);
          a_q[i] <= ain - Ang;
        end else begin
          x_q[i] <= xin + (yin >>> i);
          y_q[i] <= yin - (xin >>> i);
          a_q[i] <= ain + Ang;
        end
        f_q[i] <= fin;
      end
    end
  end

  logic signed [XW-1:0] xf, cos_r, sin_r;
  tmg_pkg::sc_t         sc_q;

  assign xf    = f_q[CORDIC_STAGES-1] ? -x_q[CORDIC_STAGES-1] : x_q[CORDIC_STAGES-1];
  assign cos_r = (xf + Half) >>> (30 - FRAC_BITS);
  assign sin_r = (y_q[CORDIC_STAGES-1] + Half) >>> (30 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.cos_v <= cos_r[31:0];
      sc_q.sin_v <= sin_r[31:0];
    end
  end

  assign sc_o = sc_q;

endmodule

### src/tmg_merge.sv
// tmg_merge: combines the three lane results and the opcode into one matrix
// four stages: products, rounding, products, rounding; depends on tmg_pkg
module tmg_merge #(
  parameter int FRAC_BITS = tmg_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  tmg_pkg::ctx_t ctx_i,
  input  tmg_pkg::sc_t  scx_i,
  input  tmg_pkg::sc_t  scy_i,
  input  tmg_pkg::sc_t  scz_i,
  output tmg_pkg::mat_t mat_o
);

  localparam tmg_pkg::entry_t One = tmg_pkg::entry_t'(32'sd1 <<< FRAC_BITS);

  tmg_pkg::ctx_t ctx_q [3];
  tmg_pkg::sc_t  scx_q [3];
  tmg_pkg::sc_t  scy_q [3];
  tmg_pkg::sc_t  scz_q [3];

  // first pass, t = rx * ry
  logic signed [63:0] p_sxsy_q, p_sxcy_q, p_cxsy_q, p_cxcy_q;
  tmg_pkg::entry_t    ta_q, tb_q, td_q, te_q;
  // second pass, t * rz
  logic signed [63:0] q_cycz_q, q_cysz_q, q_acz_q, q_cxsz_q, q_asz_q, q_cxcz_q;
  logic signed [63:0] q_dcz_q, q_sxsz_q, q_dsz_q, q_sxcz_q;
  tmg_pkg::entry_t    tb2_q, te2_q;
  tmg_pkg::mat_t      mat_d, mat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= ctx_i;
      scx_q[0] <= scx_i;
      scy_q[0] <= scy_i;
      scz_q[0] <= scz_i;
      for (int k = 1; k < 3; k++) begin
        ctx_q[k] <= ctx_q[k-1];
        scx_q[k] <= scx_q[k-1];
        scy_q[k] <= scy_q[k-1];
        scz_q[k] <= scz_q[k-1];
      end

      p_sxsy_q <= scx_i.sin_v * scy_i.sin_v;
      p_sxcy_q <= scx_i.sin_v * scy_i.cos_v;
      p_cxsy_q <= scx_i.cos_v * scy_i.sin_v;
      p_cxcy_q <= scx_i.cos_v * scy_i.cos_v;

      ta_q <= tmg_pkg::round_sat(p_sxsy_q, FRAC_BITS);
      tb_q <= tmg_pkg::round_sat(-p_sxcy_q, FRAC_BITS);
      td_q <= tmg_pkg::round_sat(-p_cxsy_q, FRAC_BITS);
      te_q <= tmg_pkg::round_sat(p_cxcy_q, FRAC_BITS);

      q_cycz_q <= scy_q[1].cos_v * scz_q[1].cos_v;
      q_cysz_q <= scy_q[1].cos_v * scz_q[1].sin_v;
      q_acz_q  <= ta_q * scz_q[1].cos_v;
      q_cxsz_q <= scx_q[1].cos_v * scz_q[1].sin_v;
      q_asz_q  <= ta_q * scz_q[1].sin_v;
      q_cxcz_q <= scx_q[1].cos_v * scz_q[1].cos_v;
      q_dcz_q  <= td_q * scz_q[1].cos_v;
      q_sxsz_q <= scx_q[1].sin_v * scz_q[1].sin_v;
      q_dsz_q  <= td_q * scz_q[1].sin_v;
      q_sxcz_q <= scx_q[1].sin_v * scz_q[1].cos_v;
      tb2_q    <= tb_q;
      te2_q    <= te_q;

      mat_q <= mat_d;
    end
  end

  always_comb begin
    tmg_pkg::ctx_t c;
    tmg_pkg::sc_t  s;
    c = ctx_q[2];
    s = scx_q[2];
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        mat_d[r][k] = (r == k) ? One : '0;
      end
    end
    unique case (tmg_pkg::op_e'(c.op))
      tmg_pkg::OP_TRANSLATE: begin
        mat_d[0][3] = c.vx;
        mat_d[1][3] = c.vy;
        mat_d[2][3] = c.vz;
      end
      tmg_pkg::OP_SCALE: begin
        mat_d[0][0] = c.vx;
        mat_d[1][1] = c.vy;
        mat_d[2][2] = c.vz;
      end
      tmg_pkg::OP_ROT_XYZ: begin
        mat_d[0][0] = tmg_pkg::round_sat(q_cycz_q, FRAC_BITS);
        mat_d[0][1] = tmg_pkg::round_sat(-q_cysz_q, FRAC_BITS);
        mat_d[0][2] = scy_q[2].sin_v;
        mat_d[1][0] = tmg_pkg::round_sat(q_acz_q + q_cxsz_q, FRAC_BITS);
        mat_d[1][1] = tmg_pkg::round_sat(q_cxcz_q - q_asz_q, FRAC_BITS);
        mat_d[1][2] = tb2_q;
        mat_d[2][0] = tmg_pkg::round_sat(q_dcz_q + q_sxsz_q, FRAC_BITS);
        mat_d[2][1] = tmg_pkg::round_sat(q_sxcz_q - q_dsz_q, FRAC_BITS);
        mat_d[2][2] = te2_q;
      end
      tmg_pkg::OP_ROT_X: begin
        mat_d[1][1] = s.cos_v;
        mat_d[1][2] = -s.sin_v;
        mat_d[2][1] = s.sin_v;
        mat_d[2][2] = s.cos_v;
      end
      tmg_pkg::OP_ROT_Y: begin
        mat_d[0][0] = s.cos_v;
        mat_d[0][2] = s.sin_v;
        mat_d[2][0] = -s.sin_v;
        mat_d[2][2] = s.cos_v;
      end
      tmg_pkg::OP_ROT_Z: begin
        mat_d[0][0] = s.cos_v;
        mat_d[0][1] = -s.sin_v;
        mat_d[1][0] = s.sin_v;
        mat_d[1][1] = s.cos_v;
      end
      default: ; // unused opcodes give identity
    endcase
  end

  assign mat_o = mat_q;

endmodule

### src/tmg_rows.sv
// tmg_rows: output register, holds one matrix and sends it one row per beat
// depends on tmg_pkg and tmg_out_if
module tmg_rows (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_valid_i,
  input  tmg_pkg::mat_t   mat_i,
  output logic            can_load_o,
  tmg_out_if.source       out_o
);

  localparam logic [1:0] LastRow = 2'd3;

  tmg_pkg::mat_t mat_q;
  logic [1:0]    cnt_q;
  logic          vld_q;
  logic          done;

  assign done       = vld_q && out_o.ready && (cnt_q == LastRow);
  assign can_load_o = !vld_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (load_valid_i && can_load_o) begin
      vld_q <= 1'b1;
      cnt_q <= '0;
    end else if (vld_q && out_o.ready) begin
      if (cnt_q == LastRow) vld_q <= 1'b0;
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && can_load_o) mat_q <= mat_i;
  end

  assign out_o.valid        = vld_q;
  assign out_o.row_index    = cnt_q;
  assign out_o.first_entry  = mat_q[cnt_q][0];
  assign out_o.second_entry = mat_q[cnt_q][1];
  assign out_o.third_entry  = mat_q[cnt_q][2];
  assign out_o.fourth_entry = mat_q[cnt_q][3];
  assign out_o.last_row     = (cnt_q == LastRow);

endmodule

### src/transform_matrix_generator_top.sv
// channel   dir   payload
// in_i      in    op_kind, x_value, y_value, z_value
// out_o     out   row_index, first..fourth_entry, last_row (four beats per item)
//
// three sin/cos lanes run side by side, one per angle, then a four-stage merge
// builds the matrix. a new item is taken whenever the pipeline is not held, also
// while earlier items are still in flight; sustained throughput is bounded by the
// four row beats per item on the output port. the whole pipeline holds when a finished
// matrix cannot move into the output register; reset clears only the valid bits and the row counter.
// depends on tmg_pkg, tmg_if, tmg_sincos, tmg_merge, tmg_rows
module transform_matrix_generator_top #(
  parameter int CORDIC_STAGES = tmg_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = tmg_pkg::FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmg_in_if.sink    in_i,
  tmg_out_if.source out_o
);

  localparam int LaneLat = tmg_pkg::lane_latency(CORDIC_STAGES, FRAC_BITS);
  localparam int Lat     = LaneLat + tmg_pkg::MergeLatency;

  logic            adv;
  logic            can_load;
  logic [Lat-1:0]  vld_q;
  tmg_pkg::ctx_t   ctx_in;
  tmg_pkg::ctx_t   ctx_q [LaneLat];
  tmg_pkg::entry_t angle [3];
  tmg_pkg::sc_t    sc [3];
  tmg_pkg::mat_t   mat;

  assign adv        = !vld_q[Lat-1] || can_load;
  assign in_i.ready = adv;

  assign ctx_in = '{op: in_i.op_kind, vx: in_i.x_value, vy: in_i.y_value,
                    vz: in_i.z_value};
  assign angle[0] = in_i.x_value;
  assign angle[1] = in_i.y_value;
  assign angle[2] = in_i.z_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // opcode and raw values ride alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0] <= ctx_in;
      for (int k = 1; k < LaneLat; k++) ctx_q[k] <= ctx_q[k-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    tmg_sincos #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .FRAC_BITS    (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .angle_i(angle[l]),
      .sc_o   (sc[l])
    );
  end

  tmg_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk_i(clk_i),
    .en_i (adv),
    .ctx_i(ctx_q[LaneLat-1]),
    .scx_i(sc[0]),
    .scy_i(sc[1]),
    .scz_i(sc[2]),
    .mat_o(mat)
  );

  tmg_rows u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(vld_q[Lat-1]),
    .mat_i       (mat),
    .can_load_o  (can_load),
    .out_o       (out_o)
  );

endmodule

### src/tmg_chk.sv
// tmg_chk: port-level checks of the transform matrix generator, bound to the top
// depends on transform_matrix_generator_top
module tmg_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] row_index_i,
  input logic       last_row_i
);

  localparam logic [1:0] LastRow = 2'd3;

  logic [1:0] exp_row_q;
  logic [7:0] pend_q;
  logic       in_beat, out_beat, mat_done;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;
  assign mat_done = out_beat && last_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
      pend_q    <= '0;
    end else begin
      if (out_beat) exp_row_q <= exp_row_q + 2'd1;
      pend_q <= pend_q + {7'd0, in_beat} - {7'd0, mat_done};
    end
  end

  // rows leave in order, four per matrix
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> row_index_i == exp_row_q)
    else $error("row beat out of order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> last_row_i == (row_index_i == LastRow))
    else $error("last_row does not match row index");

  // no matrix without an accepted item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 8'd0)
    else $error("row beat without a pending item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(row_index_i))
    else $error("stalled row beat dropped");

endmodule

bind transform_matrix_generator_top tmg_chk u_tmg_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .row_index_i(out_o.row_index),
  .last_row_i (out_o.last_row)
);
